// ===== hdl/irigfrx_pkg.sv =====
// Shared types, constants and helpers for the IRIG frame receiver.
`default_nettype none

package irigfrx_pkg;

   localparam int WIDTH_W       = 16;
   localparam int CSR_INDEX_W   = 3;
   localparam int GROUP_COUNT_W = 3;
   localparam int BIT_POS_W     = 4;
   localparam int STORE_DEPTH   = 5;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER_HIGH = 3'd5;

   // Reset values of the width windows, microseconds
   localparam logic [WIDTH_W-1:0] ZERO_LOW_RESET    = 16'd500;
   localparam logic [WIDTH_W-1:0] ZERO_HIGH_RESET   = 16'd3500;
   localparam logic [WIDTH_W-1:0] ONE_LOW_RESET     = 16'd3500;
   localparam logic [WIDTH_W-1:0] ONE_HIGH_RESET    = 16'd6500;
   localparam logic [WIDTH_W-1:0] MARKER_LOW_RESET  = 16'd6500;
   localparam logic [WIDTH_W-1:0] MARKER_HIGH_RESET = 16'd9500;

   localparam logic [BIT_POS_W-1:0] SKIP_BIT_POS = 4'd4;
   localparam logic [BIT_POS_W-1:0] BYTE_BITS    = 4'd8;

   // Class of one pulse width; the back end picks what matters for its phase
   typedef struct packed {
      logic data;       // inside the zero or the one window
      logic one;        // data bit value
      logic mark_excl;  // strictly inside the marker window
      logic mark_incl;  // inside the marker window, bounds included
      logic timeout;    // width of zero
   } class_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_SECOND = 3'b010,
      PH_RECV   = 3'b100
   } phase_type;

   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      logic [7:0] tens;
      tens = {4'b0, b[7:4]};
      return {4'b0, b[3:0]} + (tens << 3) + (tens << 1);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/irig_frame_receiver_core.sv =====
// Top level of the IRIG frame receiver: front end, queue and back end.
`default_nettype none

// IRIG-style frame receiver. Each req_ transaction carries one measured high
// pulse width in microseconds (0 means no pulse before timeout). The front
// end classes it against the six window registers as a zero bit, a one bit or
// a position marker and drops it into a two-entry queue; the back end syncs
// on two markers in a row, packs data bits LSB first (skipping the fifth bit
// of each group), stores the groups and, after FRAME_GROUPS markers or on a
// timeout, presents one rsp_ transaction with the BCD-decoded seconds,
// minutes, hours, day of year and tenths. Throughput is one width per clock
// while rsp_stall is low; an accepted width is written into the queue and
// updates the back end's state at the edge where the back end pops it, and a
// result it completes is presented from that same edge in the output register.
// While a result waits under rsp_stall the back end holds, the queue fills and
// req_stall rises. Write the window registers only while the block is idle.
module irig_frame_receiver_core #(
   parameter int FRAME_GROUPS = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Pulse width input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [irigfrx_pkg::WIDTH_W-1:0]     req_pulse_width,
   // Decoded time output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [7:0]                               rsp_seconds,
   output logic [7:0]                               rsp_minutes,
   output logic [7:0]                               rsp_hours,
   output logic [8:0]                               rsp_year_day,
   output logic [3:0]                               rsp_tenths,
   output logic                                     rsp_frame_complete,
   // Window register writes
   input  wire logic                                csr_write_enable,
   input  wire logic [irigfrx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [irigfrx_pkg::WIDTH_W-1:0]     csr_write_data
);

   irigfrx_pkg::class_type pulse_class, q_data;
   logic q_full, q_empty, q_pop, push;

   // Stall only on a full queue, never on valid
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   irigfrx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pulse_width      (req_pulse_width),
      .pulse_class      (pulse_class)
   );

   irigfrx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (pulse_class),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   irigfrx_back #(
      .FRAME_GROUPS (FRAME_GROUPS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_seconds        (rsp_seconds),
      .rsp_minutes        (rsp_minutes),
      .rsp_hours          (rsp_hours),
      .rsp_year_day       (rsp_year_day),
      .rsp_tenths         (rsp_tenths),
      .rsp_frame_complete (rsp_frame_complete)
   );

endmodule

`default_nettype wire

// ===== hdl/irigfrx_front.sv =====
// Front end: width window registers and per-transaction pulse classification.
`default_nettype none

module irigfrx_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_enable,
   input  wire logic [irigfrx_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [irigfrx_pkg::WIDTH_W-1:0]         csr_write_data,
   input  wire logic [irigfrx_pkg::WIDTH_W-1:0]         pulse_width,
   output irigfrx_pkg::class_type                       pulse_class
);

   logic [irigfrx_pkg::WIDTH_W-1:0] zero_low_ff, zero_high_ff, one_low_ff, one_high_ff;
   logic [irigfrx_pkg::WIDTH_W-1:0] marker_low_ff, marker_high_ff;
   logic in_zero, in_one;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_low_ff    <= irigfrx_pkg::ZERO_LOW_RESET;
         zero_high_ff   <= irigfrx_pkg::ZERO_HIGH_RESET;
         one_low_ff     <= irigfrx_pkg::ONE_LOW_RESET;
         one_high_ff    <= irigfrx_pkg::ONE_HIGH_RESET;
         marker_low_ff  <= irigfrx_pkg::MARKER_LOW_RESET;
         marker_high_ff <= irigfrx_pkg::MARKER_HIGH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            irigfrx_pkg::CSR_ZERO_LOW:    zero_low_ff    <= csr_write_data;
            irigfrx_pkg::CSR_ZERO_HIGH:   zero_high_ff   <= csr_write_data;
            irigfrx_pkg::CSR_ONE_LOW:     one_low_ff     <= csr_write_data;
            irigfrx_pkg::CSR_ONE_HIGH:    one_high_ff    <= csr_write_data;
            irigfrx_pkg::CSR_MARKER_LOW:  marker_low_ff  <= csr_write_data;
            irigfrx_pkg::CSR_MARKER_HIGH: marker_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Inverted or empty windows simply never match
   assign in_zero = (pulse_width > zero_low_ff) && (pulse_width < zero_high_ff);
   assign in_one  = (pulse_width > one_low_ff) && (pulse_width < one_high_ff);

   always_comb begin
      pulse_class.data      = in_zero || in_one;
      pulse_class.one       = !in_zero;
      pulse_class.mark_excl = (pulse_width > marker_low_ff) && (pulse_width < marker_high_ff);
      pulse_class.mark_incl = (pulse_width >= marker_low_ff) && (pulse_width <= marker_high_ff);
      pulse_class.timeout   = (pulse_width == '0);
   end

endmodule

`default_nettype wire

// ===== hdl/irigfrx_queue.sv =====
// Two-entry queue of classified pulses between front and back end.
`default_nettype none

module irigfrx_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire irigfrx_pkg::class_type push_data,
   output logic                        full,
   input  wire logic                   pop,
   output irigfrx_pkg::class_type      pop_data,
   output logic                        empty
);

   irigfrx_pkg::class_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/irigfrx_back.sv =====
// Back end: sync sequencer, bit packing, group store and BCD result register.
`default_nettype none

module irigfrx_back #(
   parameter int FRAME_GROUPS = 6
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   input  wire irigfrx_pkg::class_type q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_seconds,
   output logic [7:0]                  rsp_minutes,
   output logic [7:0]                  rsp_hours,
   output logic [8:0]                  rsp_year_day,
   output logic [3:0]                  rsp_tenths,
   output logic                        rsp_frame_complete
);

   localparam int GCW = irigfrx_pkg::GROUP_COUNT_W;
   localparam int BPW = irigfrx_pkg::BIT_POS_W;
   localparam int SD  = irigfrx_pkg::STORE_DEPTH;

   irigfrx_pkg::phase_type phase_ff, phase_in;
   logic [7:0]     acc_ff, acc_in;
   logic [BPW-1:0] bit_pos_ff, bit_pos_in;
   logic           skip_ff, skip_in;
   logic [GCW-1:0] group_count_ff, group_count_in;
   logic [7:0]     store_ff [SD];
   logic [7:0]     store_in [SD];
   logic           emit, complete;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     seconds_ff, minutes_ff, hours_ff;
   logic [8:0]     day_ff;
   logic [3:0]     tenths_ff;
   logic           complete_ff;

   // Advance only when a result slot is free or being drained
   assign q_pop = !q_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in       = phase_ff;
      acc_in         = acc_ff;
      bit_pos_in     = bit_pos_ff;
      skip_in        = skip_ff;
      group_count_in = group_count_ff;
      store_in       = store_ff;
      emit           = 1'b0;
      complete       = 1'b0;
      if (q_pop) begin
         case (phase_ff)
            irigfrx_pkg::PH_SECOND: begin
               if (q_data.mark_excl) begin
                  phase_in       = irigfrx_pkg::PH_RECV;
                  group_count_in = '0;
                  acc_in         = '0;
                  bit_pos_in     = '0;
                  skip_in        = 1'b1;
               end else begin
                  phase_in = irigfrx_pkg::PH_IDLE;
               end
            end
            irigfrx_pkg::PH_RECV: begin
               if (q_data.data) begin
                  if (bit_pos_ff == irigfrx_pkg::SKIP_BIT_POS && skip_ff) begin
                     skip_in = 1'b0;
                  end else if (bit_pos_ff < irigfrx_pkg::BYTE_BITS) begin
                     if (q_data.one) begin
                        acc_in = acc_ff | (8'd1 << bit_pos_ff[2:0]);
                     end
                     bit_pos_in = bit_pos_ff + BPW'(1);
                  end
               end else if (q_data.mark_excl) begin
                  for (int i = 0; i < SD; i++) begin
                     if (group_count_ff == GCW'(i)) begin
                        store_in[i] = acc_ff;
                     end
                  end
                  group_count_in = group_count_ff + GCW'(1);
                  acc_in         = '0;
                  bit_pos_in     = '0;
                  skip_in        = 1'b1;
                  if (group_count_in >= GCW'(FRAME_GROUPS)) begin
                     emit     = 1'b1;
                     complete = 1'b1;
                     phase_in = irigfrx_pkg::PH_IDLE;
                  end
               end else if (q_data.timeout) begin
                  emit     = 1'b1;
                  phase_in = irigfrx_pkg::PH_IDLE;
               end
            end
            default: begin
               // Idle and unused codes: look for the first marker
               if (q_data.mark_incl) begin
                  phase_in = irigfrx_pkg::PH_SECOND;
               end else begin
                  phase_in = irigfrx_pkg::PH_IDLE;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= irigfrx_pkg::PH_IDLE;
         acc_ff         <= '0;
         bit_pos_ff     <= '0;
         skip_ff        <= 1'b1;
         group_count_ff <= '0;
         for (int i = 0; i < SD; i++) begin
            store_ff[i] <= '0;
         end
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         acc_ff         <= acc_in;
         bit_pos_ff     <= bit_pos_in;
         skip_ff        <= skip_in;
         group_count_ff <= group_count_in;
         store_ff       <= store_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload, decoded from the store as updated by this transaction
   always_ff @(posedge clock) begin
      if (emit) begin
         seconds_ff  <= irigfrx_pkg::bcd_value(store_in[0]);
         minutes_ff  <= irigfrx_pkg::bcd_value(store_in[1]);
         hours_ff    <= irigfrx_pkg::bcd_value(store_in[2]);
         day_ff      <= {1'b0, irigfrx_pkg::bcd_value(store_in[3])}
                        + ({7'b0, store_in[4][1:0]} * 9'd100);
         tenths_ff   <= store_in[4][7:4];
         complete_ff <= complete;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_seconds        = seconds_ff;
   assign rsp_minutes        = minutes_ff;
   assign rsp_hours          = hours_ff;
   assign rsp_year_day       = day_ff;
   assign rsp_tenths         = tenths_ff;
   assign rsp_frame_complete = complete_ff;

endmodule

`default_nettype wire
